[hw/rtl/mef_pkg.sv]
// Shared types and constants for the MIDI event FIFO with statistics.
// Depends on nothing; every other file of the block uses it.
package mef_pkg;

  localparam int unsigned DEF_QUEUE_SLOTS  = 256;
  localparam int unsigned DEF_SOURCE_COUNT = 4;
  localparam int unsigned DEF_TIME_BITS    = 48;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SRC_W  = 2;
  localparam int unsigned EV_W   = 3 * BYTE_W + SRC_W;
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned STAT_W = 64;
  localparam int unsigned FILL_W = 8;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned SEL_W  = 4;

  // Number of statistic selector codes reserved for source tallies.
  localparam int unsigned SRC_SEL_SLOTS = 4;

  localparam logic [SEQ_W-1:0] PEAK_LIMIT = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_ENQ   = 3'd0,
    ACT_DEQ   = 3'd1,
    ACT_PEEK  = 3'd2,
    ACT_READ  = 3'd3,
    ACT_CLEAR = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ENQ,
    OP_DROP,
    OP_DEQ,
    OP_PEEK,
    OP_MISS,
    OP_READ,
    OP_CLEAR
  } op_t;

  localparam logic [SEL_W-1:0] STAT_ENQ      = 4'd0;
  localparam logic [SEL_W-1:0] STAT_DEQ      = 4'd1;
  localparam logic [SEL_W-1:0] STAT_DROP     = 4'd2;
  localparam logic [SEL_W-1:0] STAT_PEAK     = 4'd3;
  localparam logic [SEL_W-1:0] STAT_LAT_SUM  = 4'd4;
  localparam logic [SEL_W-1:0] STAT_LAT_PEAK = 4'd5;
  localparam logic [SEL_W-1:0] STAT_SRC0     = 4'd6;
  localparam logic [SEL_W-1:0] STAT_OVF      = 4'd10;
  localparam logic [SEL_W-1:0] STAT_RESET    = 4'd11;

  typedef struct packed {
    logic capture;
    logic commit;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             full;
    logic             empty;
  } dp_stat_t;

endpackage

[hw/rtl/mef_if.sv]
// Valid/ready channel interfaces for the MIDI event FIFO: request items in,
// result items out. Depends on mef_pkg.
interface mef_req_if #(
  parameter int unsigned TIME_BITS = mef_pkg::DEF_TIME_BITS
) ();
  logic                             valid;
  logic                             ready;
  logic [mef_pkg::ACT_W-1:0]        action;
  logic [mef_pkg::BYTE_W-1:0]       midi_status;
  logic [mef_pkg::BYTE_W-1:0]       midi_data1;
  logic [mef_pkg::BYTE_W-1:0]       midi_data2;
  logic [mef_pkg::SRC_W-1:0]        source_port;
  logic [TIME_BITS-1:0]             stamp_in;
  logic [TIME_BITS-1:0]             now_time;
  logic [mef_pkg::SEL_W-1:0]        stat_select;

  modport source (
    output valid, action, midi_status, midi_data1, midi_data2, source_port,
           stamp_in, now_time, stat_select,
    input  ready
  );
  modport sink (
    input  valid, action, midi_status, midi_data1, midi_data2, source_port,
           stamp_in, now_time, stat_select,
    output ready
  );
endinterface

interface mef_rsp_if #(
  parameter int unsigned TIME_BITS = mef_pkg::DEF_TIME_BITS
) ();
  logic                             valid;
  logic                             ready;
  logic                             ok;
  logic [mef_pkg::BYTE_W-1:0]       out_status;
  logic [mef_pkg::BYTE_W-1:0]       out_data1;
  logic [mef_pkg::BYTE_W-1:0]       out_data2;
  logic [mef_pkg::SRC_W-1:0]        out_source;
  logic [TIME_BITS-1:0]             out_stamp;
  logic [mef_pkg::SEQ_W-1:0]        out_sequence;
  logic [mef_pkg::FILL_W-1:0]       fill_level;
  logic [mef_pkg::STAT_W-1:0]       stat_value;

  modport source (
    output valid, ok, out_status, out_data1, out_data2, out_source, out_stamp,
           out_sequence, fill_level, stat_value,
    input  ready
  );
  modport sink (
    input  valid, ok, out_status, out_data1, out_data2, out_source, out_stamp,
           out_sequence, fill_level, stat_value,
    output ready
  );
endinterface

[hw/rtl/mef_ctrl.sv]
// Controller of the MIDI event FIFO: two-state sequencer, operation decode
// and the result valid flag. Depends on mef_pkg.
module mef_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mef_pkg::dp_stat_t st,
  output mef_pkg::dp_cmd_t  cmd
);
  import mef_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    case (st.act)
      ACT_ENQ:   cmd.op = st.full ? OP_DROP : OP_ENQ;
      ACT_DEQ:   cmd.op = st.empty ? OP_MISS : OP_DEQ;
      ACT_PEEK:  cmd.op = st.empty ? OP_MISS : OP_PEEK;
      ACT_READ:  cmd.op = OP_READ;
      ACT_CLEAR: cmd.op = OP_CLEAR;
      default:   cmd.op = OP_NONE;
    endcase
  end

  assign in_ready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/mef_dp.sv]
// Datapath of the MIDI event FIFO: slot memory, pointers, statistics
// counters and the result register. Depends on mef_pkg.
module mef_dp #(
  parameter int unsigned QUEUE_SLOTS  = mef_pkg::DEF_QUEUE_SLOTS,
  parameter int unsigned SOURCE_COUNT = mef_pkg::DEF_SOURCE_COUNT,
  parameter int unsigned TIME_BITS    = mef_pkg::DEF_TIME_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mef_pkg::dp_cmd_t              cmd,
  output mef_pkg::dp_stat_t             st,
  input  logic [mef_pkg::ACT_W-1:0]     action,
  input  logic [mef_pkg::BYTE_W-1:0]    midi_status,
  input  logic [mef_pkg::BYTE_W-1:0]    midi_data1,
  input  logic [mef_pkg::BYTE_W-1:0]    midi_data2,
  input  logic [mef_pkg::SRC_W-1:0]     source_port,
  input  logic [TIME_BITS-1:0]          stamp_in,
  input  logic [TIME_BITS-1:0]          now_time,
  input  logic [mef_pkg::SEL_W-1:0]     stat_select,
  output logic                          ok,
  output logic [mef_pkg::BYTE_W-1:0]    out_status,
  output logic [mef_pkg::BYTE_W-1:0]    out_data1,
  output logic [mef_pkg::BYTE_W-1:0]    out_data2,
  output logic [mef_pkg::SRC_W-1:0]     out_source,
  output logic [TIME_BITS-1:0]          out_stamp,
  output logic [mef_pkg::SEQ_W-1:0]     out_sequence,
  output logic [mef_pkg::FILL_W-1:0]    fill_level,
  output logic [mef_pkg::STAT_W-1:0]    stat_value
);
  import mef_pkg::*;

  localparam int unsigned PTR_W  = $clog2(QUEUE_SLOTS);
  localparam int unsigned SLOT_W = EV_W + TIME_BITS + SEQ_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);

  // Captured item.
  logic [ACT_W-1:0]     act;
  logic [EV_W-1:0]      ev_bytes;
  logic [TIME_BITS-1:0] ev_stamp;
  logic [TIME_BITS-1:0] now;
  logic [SEL_W-1:0]     sel;

  logic [SLOT_W-1:0]    slots [QUEUE_SLOTS];
  logic [SLOT_W-1:0]    rd_word;

  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W-1:0]     count;
  logic [SEQ_W-1:0]     seq_counter;
  logic [STAT_W-1:0]    enq_tally;
  logic [STAT_W-1:0]    deq_tally;
  logic [STAT_W-1:0]    drop_tally;
  logic [STAT_W-1:0]    ovf_tally;
  logic [PTR_W-1:0]     peak_fill;
  logic [STAT_W-1:0]    lat_total;
  logic [SEQ_W-1:0]     lat_peak;
  logic [STAT_W-1:0]    src_tally [SOURCE_COUNT];
  logic [TIME_BITS-1:0] reset_stamp;
  logic [TIME_BITS-1:0] lat_held;
  logic                 lat_pend;

  logic [EV_W-1:0]      rd_bytes;
  logic [TIME_BITS-1:0] rd_stamp;
  logic [SEQ_W-1:0]     rd_seq;
  logic [TIME_BITS-1:0] lat;
  logic [SEQ_W-1:0]     lat_sat;
  logic [PTR_W-1:0]     count_inc;
  logic [PTR_W-1:0]     fill_after;
  logic [STAT_W-1:0]    stat_sel_val;
  logic                 hit;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  assign rd_bytes = rd_word[SLOT_W-1 -: EV_W];
  assign rd_stamp = rd_word[SEQ_W +: TIME_BITS];
  assign rd_seq   = rd_word[SEQ_W-1:0];

  assign lat     = (now > rd_stamp) ? now - rd_stamp : '0;
  assign lat_sat = ((lat_held >> SEQ_W) != '0) ? PEAK_LIMIT : lat_held[SEQ_W-1:0];

  assign count_inc = count + 1'b1;
  assign hit       = (cmd.op == OP_DEQ) || (cmd.op == OP_PEEK);

  assign st.act   = act;
  assign st.full  = (count == LAST_SLOT);
  assign st.empty = (count == '0);

  always_comb begin
    case (cmd.op)
      OP_ENQ:  fill_after = count_inc;
      OP_DEQ:  fill_after = count - 1'b1;
      default: fill_after = count;
    endcase
  end

  always_comb begin
    stat_sel_val = '0;
    case (sel)
      STAT_ENQ:      stat_sel_val = enq_tally;
      STAT_DEQ:      stat_sel_val = deq_tally;
      STAT_DROP:     stat_sel_val = drop_tally;
      STAT_PEAK:     stat_sel_val = STAT_W'(peak_fill);
      STAT_LAT_SUM:  stat_sel_val = lat_total;
      STAT_LAT_PEAK: stat_sel_val = STAT_W'(lat_peak);
      STAT_OVF:      stat_sel_val = ovf_tally;
      STAT_RESET:    stat_sel_val = STAT_W'(reset_stamp);
      default: begin
        for (int i = 0; i < SOURCE_COUNT; i++) begin
          if (i < SRC_SEL_SLOTS && int'(sel) == int'(STAT_SRC0) + i) begin
            stat_sel_val = src_tally[i];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act      <= action;
      ev_bytes <= {midi_status, midi_data1, midi_data2, source_port};
      ev_stamp <= (stamp_in == '0) ? now_time : stamp_in;
      now      <= now_time;
      sel      <= stat_select;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && cmd.op == OP_ENQ) begin
      slots[wr_ptr] <= {ev_bytes, ev_stamp, seq_counter};
    end
    if (cmd.capture) begin
      rd_word <= slots[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
      seq_counter <= '0;
      enq_tally   <= '0;
      deq_tally   <= '0;
      drop_tally  <= '0;
      ovf_tally   <= '0;
      peak_fill   <= '0;
      lat_total   <= '0;
      lat_peak    <= '0;
      reset_stamp <= '0;
      lat_pend    <= 1'b0;
      for (int i = 0; i < SOURCE_COUNT; i++) begin
        src_tally[i] <= '0;
      end
    end else begin
      // The latency of a dequeue is held in lat_held and folded into the totals in the cycle after.
      if (lat_pend) begin
        lat_total <= lat_total + STAT_W'(lat_held);
        if (lat_sat > lat_peak) begin
          lat_peak <= lat_sat;
        end
        lat_pend <= 1'b0;
      end
      if (cmd.commit) begin
        case (cmd.op)
          OP_ENQ: begin
            wr_ptr      <= next_slot(wr_ptr);
            count       <= count_inc;
            seq_counter <= seq_counter + 1'b1;
            enq_tally   <= enq_tally + 1'b1;
            if (count_inc > peak_fill) begin
              peak_fill <= count_inc;
            end
            for (int i = 0; i < SOURCE_COUNT; i++) begin
              if (int'(ev_bytes[SRC_W-1:0]) == i) begin
                src_tally[i] <= src_tally[i] + 1'b1;
              end
            end
          end
          OP_DROP: begin
            drop_tally <= drop_tally + 1'b1;
            ovf_tally  <= ovf_tally + 1'b1;
          end
          OP_DEQ: begin
            rd_ptr    <= next_slot(rd_ptr);
            count     <= count - 1'b1;
            deq_tally <= deq_tally + 1'b1;
            lat_held  <= lat;
            lat_pend  <= 1'b1;
          end
          OP_CLEAR: begin
            enq_tally   <= '0;
            deq_tally   <= '0;
            drop_tally  <= '0;
            ovf_tally   <= '0;
            peak_fill   <= '0;
            lat_total   <= '0;
            lat_peak    <= '0;
            reset_stamp <= now;
            for (int i = 0; i < SOURCE_COUNT; i++) begin
              src_tally[i] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok         <= (cmd.op == OP_ENQ) || hit;
      out_status <= hit ? rd_bytes[EV_W-1 -: BYTE_W] : '0;
      out_data1  <= hit ? rd_bytes[EV_W-BYTE_W-1 -: BYTE_W] : '0;
      out_data2  <= hit ? rd_bytes[SRC_W +: BYTE_W] : '0;
      out_source <= hit ? rd_bytes[SRC_W-1:0] : '0;
      out_stamp  <= hit ? rd_stamp : '0;
      out_sequence <= hit ? rd_seq : '0;
      fill_level <= FILL_W'(fill_after);
      stat_value <= (cmd.op == OP_READ) ? stat_sel_val : '0;
    end
  end

endmodule

[hw/rtl/midi_event_fifo_with_stats_unit.sv]
// Top level of the MIDI event FIFO with statistics: controller, datapath
// and checks. Depends on mef_pkg, mef_if, mef_ctrl and mef_dp.
//
//   Channel   Direction   Carries
//   req       in          action, event bytes, source, stamps, statistic select
//   rsp       out         ok, event fields, fill level, statistic value
//
// Each item is first captured, with the oldest slot read from the slot memory,
// and then executed, which loads the result register.
// A new item is taken while the previous result waits on rsp; execution
// stalls only while the result register is still full.
// Reset is synchronous and clears pointers and statistics at once; the slot
// memory needs no clearing, since every slot is written before it is read.
module midi_event_fifo_with_stats_unit #(
  parameter int unsigned QUEUE_SLOTS  = mef_pkg::DEF_QUEUE_SLOTS,
  parameter int unsigned SOURCE_COUNT = mef_pkg::DEF_SOURCE_COUNT,
  parameter int unsigned TIME_BITS    = mef_pkg::DEF_TIME_BITS
) (
  input logic       clk,
  input logic       rst,
  mef_req_if.sink   req,
  mef_rsp_if.source rsp
);
  import mef_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  mef_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  mef_dp #(
    .QUEUE_SLOTS  (QUEUE_SLOTS),
    .SOURCE_COUNT (SOURCE_COUNT),
    .TIME_BITS    (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .action       (req.action),
    .midi_status  (req.midi_status),
    .midi_data1   (req.midi_data1),
    .midi_data2   (req.midi_data2),
    .source_port  (req.source_port),
    .stamp_in     (req.stamp_in),
    .now_time     (req.now_time),
    .stat_select  (req.stat_select),
    .ok           (rsp.ok),
    .out_status   (rsp.out_status),
    .out_data1    (rsp.out_data1),
    .out_data2    (rsp.out_data2),
    .out_source   (rsp.out_source),
    .out_stamp    (rsp.out_stamp),
    .out_sequence (rsp.out_sequence),
    .fill_level   (rsp.fill_level),
    .stat_value   (rsp.stat_value)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("A second item was offered a slot while one is in flight.");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp.valid)
    else $error("An executed item did not appear on the result channel.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !cmd.commit)
    else $error("A waiting result was overwritten.");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(st.full && st.empty))
    else $error("The queue reports full and empty together.");

endmodule
